// ===== rtl/pac_pkg.sv =====
package pac_pkg;

  // profile geometry
  localparam int PROFILE_SIZE  = 5;
  localparam int ELEMENT_WIDTH = 12;
  localparam int NUM_ROWS      = 5;
  localparam int ROW_W         = 60;
  localparam int FRAC_W        = 8;

  // score format, Q15.8
  localparam int SCORE_W   = 24;
  localparam int SCORE_MAX = 8388607;
  localparam int SCORE_MIN = -8388608;

  // floored q * t product, lane partial sum, floored pp * r term, merged sum
  localparam int PROD_W  = 2 * ELEMENT_WIDTH - FRAC_W;
  localparam int PP_W    = PROD_W + $clog2(PROFILE_SIZE);
  localparam int TERM_W  = PP_W + ELEMENT_WIDTH - FRAC_W;
  localparam int MATCH_W = TERM_W + $clog2(PROFILE_SIZE);
  localparam int SAT_W   = (MATCH_W > SCORE_W + 1) ? MATCH_W : SCORE_W + 1;

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;
  typedef elem_t                           elem_vec_t [PROFILE_SIZE];
  typedef logic signed [TERM_W-1:0]        term_t;
  typedef logic signed [SCORE_W-1:0]       score_t;

  typedef struct packed {
    score_t up;
    score_t diag;
    score_t left;
  } score_set_t;

  typedef enum logic [1:0] {
    DIR_UP   = 2'd0,
    DIR_DIAG = 2'd1,
    DIR_LEFT = 2'd2
  } dir_t;

  // element k of a packed field; anything past the field reads as zero
  function automatic elem_t elem(input logic [ROW_W-1:0] v, input int k);
    logic [ROW_W+PROFILE_SIZE*ELEMENT_WIDTH-1:0] padded;
    padded = {{(PROFILE_SIZE*ELEMENT_WIDTH){1'b0}}, v};
    return $signed(padded[k*ELEMENT_WIDTH +: ELEMENT_WIDTH]);
  endfunction

  function automatic score_t sat_score(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(SCORE_MAX);
    lo = SAT_W'(SCORE_MIN);
    if (v > hi) begin
      return hi[SCORE_W-1:0];
    end else if (v < lo) begin
      return lo[SCORE_W-1:0];
    end
    return v[SCORE_W-1:0];
  endfunction

endpackage

// ===== rtl/profile_alignment_cell.sv =====
// One cell of a global profile-to-profile alignment with a linear gap
// penalty. Each item carries two profiles and three neighbor scores; the
// block returns the new cell score and a traceback direction. It is a fixed
// 8-register pipeline that takes one item every cycle: busy is always low.
// out_valid rises once the item has passed one input register, three stages in
// each of the five per-column lanes and four stages in the merge. Results
// cannot be held off, so the receiver must take them as they come. Transition
// rows and the gap penalty sit on the APB port at byte addresses 8*i and must
// only be written while no item is in flight.
module profile_alignment_cell
  import pac_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  // item input
  input  logic               start,
  output logic               busy,
  input  logic [ROW_W-1:0]   in_query_profile,
  input  logic [ROW_W-1:0]   in_reference_profile,
  input  logic signed [SCORE_W-1:0] in_up_score,
  input  logic signed [SCORE_W-1:0] in_diag_score,
  input  logic signed [SCORE_W-1:0] in_left_score,
  // results
  output logic               out_valid,
  output logic signed [SCORE_W-1:0] out_cell_score_out,
  output logic [1:0]         out_direction
);

  localparam int          LANE_LAT     = 3;
  localparam logic [2:0]  REG_ROW_LAST = 3'(NUM_ROWS - 1);
  localparam logic [2:0]  REG_GAP      = 3'(NUM_ROWS);

  // config registers
  logic [ROW_W-1:0] trow_r [NUM_ROWS];
  score_t           gap_r;
  logic [2:0]       reg_idx;
  logic             cfg_wr;

  // input stage and the score/valid delay line alongside the lanes
  logic             accept;
  logic [ROW_W-1:0] q_r, rf_r;
  score_set_t       sc_r [LANE_LAT+1];
  logic             vld_r [LANE_LAT+1];

  elem_vec_t        q_vec;
  elem_vec_t        r_vec;
  elem_vec_t        t_col [PROFILE_SIZE];
  term_t            terms [PROFILE_SIZE];
  dir_t             dir;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        trow_r[r] <= '0;
      end
      gap_r <= '0;
    end else if (cfg_wr) begin
      // addresses past the gap register are dropped
      if (reg_idx <= REG_ROW_LAST) begin
        trow_r[reg_idx] <= pwdata[ROW_W-1:0];
      end else if (reg_idx == REG_GAP) begin
        gap_r <= pwdata[SCORE_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx <= REG_ROW_LAST) begin
      prdata = 64'(trow_r[reg_idx]);
    end else if (reg_idx == REG_GAP) begin
      prdata = 64'(unsigned'(gap_r));
    end
  end

  // item pipeline: valid bits reset, payload does not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= LANE_LAT; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[0] <= accept;
      for (int s = 1; s <= LANE_LAT; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
    q_r        <= in_query_profile;
    rf_r       <= in_reference_profile;
    sc_r[0]    <= '{up: in_up_score, diag: in_diag_score, left: in_left_score};
    for (int s = 1; s <= LANE_LAT; s++) begin
      sc_r[s] <= sc_r[s-1];
    end
  end

  // unpack elements; lane i gets column i of T, rows past the fifth are zero
  for (genvar j = 0; j < PROFILE_SIZE; j++) begin : g_unpack
    assign q_vec[j] = elem(q_r, j);
    assign r_vec[j] = elem(rf_r, j);
    for (genvar i = 0; i < PROFILE_SIZE; i++) begin : g_col
      if (j < NUM_ROWS) begin : g_row
        assign t_col[i][j] = elem(trow_r[j], i);
      end else begin : g_zero
        assign t_col[i][j] = '0;
      end
    end
  end

  for (genvar i = 0; i < PROFILE_SIZE; i++) begin : g_lane
    pac_lane u_lane (
      .clk    (clk),
      .q_elem (q_vec),
      .t_col  (t_col[i]),
      .r_elem (r_vec[i]),
      .term   (terms[i])
    );
  end

  // sums lane terms into the match score, then picks the best predecessor
  pac_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_r[LANE_LAT]),
    .terms     (terms),
    .scores    (sc_r[LANE_LAT]),
    .gap       (gap_r),
    .out_valid (out_valid),
    .out_score (out_cell_score_out),
    .out_dir   (dir)
  );

  assign out_direction = dir;

  // every accepted item comes out on out_valid after the full pipeline
  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##8 out_valid)
    else $error("accepted item produced no result");

  // no result without a matching accepted item
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 8))
    else $error("result without a matching item");

endmodule

// ===== rtl/pac_lane.sv =====
module pac_lane
  import pac_pkg::*;
(
  input  logic      clk,
  input  elem_vec_t q_elem,
  input  elem_vec_t t_col,
  input  elem_t     r_elem,
  output term_t     term
);

  logic signed [PROD_W-1:0] prod_r [PROFILE_SIZE];
  logic signed [PROD_W-1:0] prod_nxt [PROFILE_SIZE];
  logic signed [PP_W-1:0]   pp_r;
  logic signed [PP_W-1:0]   pp_nxt;
  elem_t                    r_a_r;
  elem_t                    r_b_r;
  logic signed [PP_W+ELEMENT_WIDTH-1:0] term_full;
  term_t                    term_r;

  // stage A: q[j] * T[j][i], floored to 8 fraction bits
  always_comb begin
    logic signed [2*ELEMENT_WIDTH-1:0] p;
    for (int j = 0; j < PROFILE_SIZE; j++) begin
      p           = q_elem[j] * t_col[j];
      prod_nxt[j] = p[2*ELEMENT_WIDTH-1:FRAC_W];
    end
  end

  // stage B: lane sum; cannot reach the score limits, so no clamp
  always_comb begin
    pp_nxt = '0;
    for (int j = 0; j < PROFILE_SIZE; j++) begin
      pp_nxt = pp_nxt + PP_W'(prod_r[j]);
    end
  end

  // stage C: pp * r, floored
  assign term_full = pp_r * r_b_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    r_a_r  <= r_elem;
    pp_r   <= pp_nxt;
    r_b_r  <= r_a_r;
    term_r <= term_full[PP_W+ELEMENT_WIDTH-1:FRAC_W];
  end

  assign term = term_r;

endmodule

// ===== rtl/pac_merge.sv =====
module pac_merge
  import pac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  term_t      terms [PROFILE_SIZE],
  input  score_set_t scores,
  input  score_t     gap,
  output logic       out_valid,
  output score_t     out_score,
  output dir_t       out_dir
);

  // stage D
  logic   d_valid_r;
  score_t match_r, del_r, ins_r, diag_r;
  score_t match_nxt;
  // stage E
  logic   e_valid_r;
  score_t e_match_r, e_del_r, e_ins_r, dg_r;
  // stage F
  logic   f_valid_r;
  score_t f_match_r, best_r;
  dir_t   dir_r;
  score_t best_nxt;
  dir_t   dir_nxt;
  // stage G
  logic   g_valid_r;
  score_t score_r;
  dir_t   g_dir_r;

  always_comb begin
    logic signed [SAT_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < PROFILE_SIZE; i++) begin
      acc = acc + SAT_W'(terms[i]);
    end
    match_nxt = sat_score(acc);
  end

  // ties stay with the earlier candidate: up, then diagonal, then left
  always_comb begin
    best_nxt = e_del_r;
    dir_nxt  = DIR_UP;
    if (best_nxt < dg_r) begin
      best_nxt = dg_r;
      dir_nxt  = DIR_DIAG;
    end
    if (best_nxt < e_ins_r) begin
      best_nxt = e_ins_r;
      dir_nxt  = DIR_LEFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
      f_valid_r <= 1'b0;
      g_valid_r <= 1'b0;
    end else begin
      d_valid_r <= in_valid;
      e_valid_r <= d_valid_r;
      f_valid_r <= e_valid_r;
      g_valid_r <= f_valid_r;
    end
    match_r   <= match_nxt;
    del_r     <= sat_score(SAT_W'(scores.up) + SAT_W'(gap));
    ins_r     <= sat_score(SAT_W'(scores.left) + SAT_W'(gap));
    diag_r    <= scores.diag;
    e_match_r <= match_r;
    e_del_r   <= del_r;
    e_ins_r   <= ins_r;
    dg_r      <= sat_score(SAT_W'(diag_r) + SAT_W'(match_r));
    f_match_r <= e_match_r;
    best_r    <= best_nxt;
    dir_r     <= dir_nxt;
    score_r   <= sat_score(SAT_W'(f_match_r) + SAT_W'(best_r));
    g_dir_r   <= dir_r;
  end

  assign out_valid = g_valid_r;
  assign out_score = score_r;
  assign out_dir   = g_dir_r;

endmodule
